[design/clsop_pkg.sv]
package clsop_pkg;

  localparam int MaxSpheres   = 1024;
  localparam int SphW         = $clog2(MaxSpheres);
  localparam int LinkW        = SphW + 1;
  localparam int MaxCellsAxis = 16;
  localparam int AxW          = $clog2(MaxCellsAxis);
  localparam int CellSlots    = MaxCellsAxis * MaxCellsAxis * MaxCellsAxis;
  localparam int SlotW        = $clog2(CellSlots);
  localparam int CoordW       = 20;
  localparam int RadW         = 16;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;

  localparam logic [2:0] REG_CELLS_X = 3'd0;
  localparam logic [2:0] REG_CELLS_Y = 3'd1;
  localparam logic [2:0] REG_CELLS_Z = 3'd2;
  localparam logic [2:0] REG_BOX_X   = 3'd3;
  localparam logic [2:0] REG_BOX_Y   = 3'd4;
  localparam logic [2:0] REG_BOX_Z   = 3'd5;
  localparam logic [2:0] REG_PROBE_R = 3'd6;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [RadW-1:0]          sphere_radius;
  } in_item_t;

  typedef struct packed {
    logic        overlap;
    logic        status;
    logic [31:0] hit_total;
    logic [31:0] trial_total;
  } out_item_t;

endpackage

[design/clsop_cell_div.sv]
// Cell index along one axis: floor((p + box/2)*n/box), clamped. Restoring division, one bit a cycle.
module clsop_cell_div import clsop_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [CoordW-1:0] pos,
  input  logic [CoordW-1:0]        box,
  input  logic [AxW:0]             ncell,
  output logic                     done,
  output logic [AxW-1:0]           cell_idx
);

  localparam int NumW = CoordW + 1 + AxW + 1;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0]   num_r, num_nxt;
  logic [CoordW:0]   rem_r, rem_nxt;
  logic [NumW-1:0]   quo_r, quo_nxt;
  logic [CoordW-1:0] den_r;
  logic [AxW:0]      n_r;
  logic              neg_r;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [CoordW-1:0] box_e;
  logic signed [CoordW+1:0] p_s;
  logic [CoordW+1:0] trial;

  always_comb begin
    box_e = (box == '0) ? CoordW'(1) : box;
    p_s = (CoordW+2)'(pos) + (CoordW+2)'({1'b0, box_e[CoordW-1:1]});
    trial = {rem_r, num_r[NumW-1]};
    rem_nxt = rem_r;
    num_nxt = num_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      num_nxt = num_r << 1;
      if (trial >= {2'b0, den_r}) begin
        rem_nxt = (CoordW+1)'(trial - {2'b0, den_r});
        quo_nxt = {quo_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CoordW:0];
        quo_nxt = {quo_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= done_nxt;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(NumW);
      end else begin
        busy_r <= busy_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
    if (start) begin
      neg_r <= p_s[CoordW+1];
      num_r <= NumW'(p_s[CoordW:0]) * NumW'(ncell);
      den_r <= box_e;
      n_r   <= ncell;
      rem_r <= '0;
      quo_r <= '0;
    end else begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  logic [AxW:0] nm1;
  assign nm1  = n_r - 1'b1;
  assign done = done_r;
  assign cell_idx = neg_r ? '0 :
                    (quo_r >= NumW'(n_r)) ? nm1[AxW-1:0] : quo_r[AxW-1:0];

endmodule

[design/cell_list_sphere_overlap_probe.sv]
// Cell-list sphere overlap probe. Each transfer yields one result. A finished result waits in
// the output register; the block still takes the next item and holds only at that item's end
// until the register is free. A clear queues its result, then sweeps the 4096-entry head table,
// one entry a cycle; the same sweep runs once after reset before any item is taken. A load
// runs the three cell-index divisions, then writes its sphere and its cell's head (a load
// into a full table only sets status). A probe runs the same divisions, then for each of the
// 27 neighbor cells does one head read and, per chained sphere, one read and three
// multiply-accumulate steps on a shared 23x23 multiplier; an overlap ends the walk early.
module cell_list_sphere_overlap_probe import clsop_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_item_t      in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output out_item_t     out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [19:0]   cfg_data
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DIV, S_DIVW, S_LOADW, S_NBR, S_HEAD, S_HEADW, S_SPH, S_SPHW,
    S_MX, S_MY, S_MZ, S_CMP, S_OUT
  } state_t;

  logic [4:0]  cells_x_r, cells_y_r, cells_z_r;
  logic [19:0] box_x_r, box_y_r, box_z_r;
  logic [15:0] probe_r_r;

  logic [CoordW-1:0] sx_mem [MaxSpheres];
  logic [CoordW-1:0] sy_mem [MaxSpheres];
  logic [CoordW-1:0] sz_mem [MaxSpheres];
  logic [RadW-1:0]   sr_mem [MaxSpheres];
  logic [LinkW-1:0]  nl_mem [MaxSpheres];
  logic [LinkW-1:0]  hd_mem [CellSlots];

  state_t state_r;
  in_item_t item_r;
  logic [LinkW-1:0] count_r;
  logic [31:0] hit_r, trial_r;
  logic [SlotW-1:0] clr_r;
  logic [1:0] ax_r;
  logic [AxW-1:0] cx_r, cy_r, cz_r;
  logic [1:0] dx_r, dy_r, dz_r;
  logic signed [CoordW+1:0] shx_r, shy_r, shz_r;
  logic [LinkW-1:0] n_r, hd_q_r, nl_q_r;
  logic [SphW:0] steps_r;
  logic [CoordW-1:0] qx_r, qy_r, qz_r;
  logic [RadW-1:0] qr_r;
  logic [63:0] acc_r;
  logic ov_r;
  logic st_r;
  out_item_t res_r;
  logic ovalid_r;

  logic [AxW:0] nx, ny, nz;
  function automatic logic [AxW:0] eff_c(input logic [4:0] c);
    if (c == 5'd0) return (AxW+1)'(1);
    if (c > 5'(MaxCellsAxis)) return (AxW+1)'(MaxCellsAxis);
    return (AxW+1)'(c);
  endfunction
  function automatic logic [19:0] eff_b(input logic [19:0] b);
    return (b == '0) ? 20'd1 : b;
  endfunction
  assign nx = eff_c(cells_x_r);
  assign ny = eff_c(cells_y_r);
  assign nz = eff_c(cells_z_r);

  logic div_start, div_done;
  logic signed [CoordW-1:0] div_pos;
  logic [CoordW-1:0] div_box;
  logic [AxW:0] div_n;
  logic [AxW-1:0] div_cell;
  always_comb begin
    div_start = (state_r == S_DIV);
    unique case (ax_r)
      2'd0: begin div_pos = item_r.pos_x; div_box = box_x_r; div_n = nx; end
      2'd1: begin div_pos = item_r.pos_y; div_box = box_y_r; div_n = ny; end
      default: begin div_pos = item_r.pos_z; div_box = box_z_r; div_n = nz; end
    endcase
  end
  clsop_cell_div u_div (
    .clk, .rst_n, .start(div_start), .pos(div_pos), .box(div_box), .ncell(div_n),
    .done(div_done), .cell_idx(div_cell)
  );

  // neighbor index and shift along one axis; d = 0,1,2 for -1,0,+1
  logic [AxW-1:0] jx, jy, jz;
  logic signed [CoordW+1:0] tsx, tsy, tsz;
  function automatic logic [AxW:0] wrap_idx(input logic [AxW-1:0] c, input logic [1:0] d,
                                             input logic [AxW:0] n);
    logic [AxW+1:0] t;
    t = (AxW+2)'(c) + (AxW+2)'(d);
    if (t == '0) return n - 1'b1;
    if (t - 1'b1 >= (AxW+2)'(n)) return '0;
    return (AxW+1)'(t - 1'b1);
  endfunction
  function automatic logic signed [CoordW+1:0] wrap_sh(input logic [AxW-1:0] c,
      input logic [1:0] d, input logic [AxW:0] n, input logic [19:0] b);
    logic [AxW+1:0] t;
    t = (AxW+2)'(c) + (AxW+2)'(d);
    if (t == '0) return -$signed({2'b0, b});
    if (t - 1'b1 >= (AxW+2)'(n)) return $signed({2'b0, b});
    return '0;
  endfunction
  logic [AxW:0] jxw, jyw, jzw;
  always_comb begin
    jxw = wrap_idx(cx_r, dx_r, nx);
    jyw = wrap_idx(cy_r, dy_r, ny);
    jzw = wrap_idx(cz_r, dz_r, nz);
    jx = jxw[AxW-1:0];
    jy = jyw[AxW-1:0];
    jz = jzw[AxW-1:0];
    tsx = wrap_sh(cx_r, dx_r, nx, eff_b(box_x_r));
    tsy = wrap_sh(cy_r, dy_r, ny, eff_b(box_y_r));
    tsz = wrap_sh(cz_r, dz_r, nz, eff_b(box_z_r));
  end

  // slot = (z*ny + y)*nx + x, small multiplies
  logic [SlotW-1:0] slot_j, slot_c;
  assign slot_j = SlotW'((SlotW'(jz) * SlotW'(ny) + SlotW'(jy)) * SlotW'(nx) + SlotW'(jx));
  assign slot_c = SlotW'((SlotW'(cz_r) * SlotW'(ny) + SlotW'(cy_r)) * SlotW'(nx)
                  + SlotW'(cx_r));

  // shared multiplier: squares one difference per step, or the radius sum for the compare
  logic signed [CoordW+2:0] diff;
  logic [CoordW+2:0] mag;
  logic [45:0] sqv;
  always_comb begin
    unique case (state_r)
      S_MX: diff = (CoordW+3)'($signed(qx_r)) + (CoordW+3)'(shx_r)
                   - (CoordW+3)'(item_r.pos_x);
      S_MY: diff = (CoordW+3)'($signed(qy_r)) + (CoordW+3)'(shy_r)
                   - (CoordW+3)'(item_r.pos_y);
      S_MZ: diff = (CoordW+3)'($signed(qz_r)) + (CoordW+3)'(shz_r)
                   - (CoordW+3)'(item_r.pos_z);
      default: diff = (CoordW+3)'({1'b0, qr_r}) + (CoordW+3)'({1'b0, probe_r_r});
    endcase
    mag = diff[CoordW+2] ? (CoordW+3)'(-diff) : diff;
    sqv = 46'(mag) * 46'(mag);
  end

  logic [SphW-1:0] n_idx;
  assign n_idx = n_r[SphW-1:0];
  logic link_ok;
  assign link_ok = (n_r < count_r) && (steps_r < (SphW+1)'(MaxSpheres));
  logic last_nbr;
  assign last_nbr = (dx_r == 2'd2) && (dy_r == 2'd2) && (dz_r == 2'd2);

  always_ff @(posedge clk) begin
    if (state_r == S_CLR) hd_mem[clr_r] <= LinkW'(MaxSpheres);
    else if (state_r == S_LOADW) hd_mem[slot_c] <= count_r;
    hd_q_r <= hd_mem[(state_r == S_LOADW || state_r == S_NBR) ? slot_c : slot_j];
    if (state_r == S_LOADW) begin
      sx_mem[count_r[SphW-1:0]] <= item_r.pos_x;
      sy_mem[count_r[SphW-1:0]] <= item_r.pos_y;
      sz_mem[count_r[SphW-1:0]] <= item_r.pos_z;
      sr_mem[count_r[SphW-1:0]] <= item_r.sphere_radius;
    end
    qx_r <= sx_mem[n_idx];
    qy_r <= sy_mem[n_idx];
    qz_r <= sz_mem[n_idx];
    qr_r <= sr_mem[n_idx];
    nl_q_r <= nl_mem[n_idx];
  end

  // the link write needs the current head, read in the cycle before
  logic load_link;
  always_ff @(posedge clk) begin
    if (load_link) nl_mem[count_r[SphW-1:0]] <= hd_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r <= 5'd16; cells_y_r <= 5'd16; cells_z_r <= 5'd16;
      box_x_r <= 20'd65536; box_y_r <= 20'd65536; box_z_r <= 20'd65536;
      probe_r_r <= 16'd384;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELLS_X: cells_x_r <= cfg_data[4:0];
        REG_CELLS_Y: cells_y_r <= cfg_data[4:0];
        REG_CELLS_Z: cells_z_r <= cfg_data[4:0];
        REG_BOX_X:   box_x_r <= cfg_data;
        REG_BOX_Y:   box_y_r <= cfg_data;
        REG_BOX_Z:   box_z_r <= cfg_data;
        REG_PROBE_R: probe_r_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      count_r <= '0;
      hit_r <= '0;
      trial_r <= '0;
      ovalid_r <= 1'b0;
      load_link <= 1'b0;
    end else begin
      load_link <= 1'b0;
      if (out_valid && !out_stall) ovalid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SlotW'(CellSlots - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item_r <= in_data;
            ov_r <= 1'b0;
            st_r <= 1'b0;
            ax_r <= 2'd0;
            unique case (in_data.op)
              OP_CLEAR: begin
                count_r <= '0; hit_r <= '0; trial_r <= '0;
                clr_r <= '0;
                state_r <= S_OUT;
              end
              OP_LOAD: begin
                if (count_r >= LinkW'(MaxSpheres)) begin
                  st_r <= 1'b1;
                  state_r <= S_OUT;
                end else state_r <= S_DIV;
              end
              OP_PROBE: state_r <= S_DIV;
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_DIV: state_r <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            unique case (ax_r)
              2'd0: cx_r <= div_cell;
              2'd1: cy_r <= div_cell;
              default: cz_r <= div_cell;
            endcase
            if (ax_r == 2'd2) begin
              dx_r <= '0; dy_r <= '0; dz_r <= '0;
              state_r <= (item_r.op == OP_LOAD) ? S_NBR : S_HEAD;
            end else begin
              ax_r <= ax_r + 1'b1;
              state_r <= S_DIV;
            end
          end
        end
        S_NBR: begin
          load_link <= 1'b1;
          state_r <= S_LOADW;
        end
        S_LOADW: begin
          count_r <= count_r + 1'b1;
          state_r <= S_OUT;
        end
        S_HEAD: begin
          shx_r <= tsx; shy_r <= tsy; shz_r <= tsz;
          state_r <= S_HEADW;
        end
        S_HEADW: begin
          n_r <= hd_q_r;
          steps_r <= '0;
          state_r <= S_SPH;
        end
        S_SPH: begin
          if (link_ok) state_r <= S_SPHW;
          else if (last_nbr) state_r <= S_OUT;
          else begin
            if (dx_r != 2'd2) dx_r <= dx_r + 1'b1;
            else begin
              dx_r <= '0;
              if (dy_r != 2'd2) dy_r <= dy_r + 1'b1;
              else begin
                dy_r <= '0;
                dz_r <= dz_r + 1'b1;
              end
            end
            state_r <= S_HEAD;
          end
        end
        S_SPHW: begin
          acc_r <= '0;
          state_r <= S_MX;
        end
        S_MX: begin acc_r <= acc_r + 64'(sqv); state_r <= S_MY; end
        S_MY: begin acc_r <= acc_r + 64'(sqv); state_r <= S_MZ; end
        S_MZ: begin acc_r <= acc_r + 64'(sqv); state_r <= S_CMP; end
        S_CMP: begin
          if ({acc_r[61:0], 2'b00} < 64'(sqv[33:0])) begin
            ov_r <= 1'b1;
            state_r <= S_OUT;
          end else begin
            n_r <= nl_q_r;
            steps_r <= steps_r + 1'b1;
            state_r <= S_SPH;
          end
        end
        S_OUT: begin
          // hold until the previous result has been taken
          if (!ovalid_r) begin
            res_r.overlap <= ov_r;
            res_r.status <= st_r;
            if (item_r.op == OP_PROBE) begin
              res_r.hit_total <= (ov_r && hit_r != '1) ? hit_r + 1'b1 : hit_r;
              res_r.trial_total <= (trial_r != '1) ? trial_r + 1'b1 : trial_r;
              if (ov_r && hit_r != '1) hit_r <= hit_r + 1'b1;
              if (trial_r != '1) trial_r <= trial_r + 1'b1;
            end else begin
              res_r.hit_total <= hit_r;
              res_r.trial_total <= trial_r;
            end
            ovalid_r <= 1'b1;
            state_r <= (item_r.op == OP_CLEAR) ? S_CLR : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = res_r;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import clsop_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [19:0] cfg_data;

  cell_list_sphere_overlap_probe dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // geometry and table mirror
  logic [4:0] m_cells [3];
  logic [19:0] m_box [3];
  logic [15:0] m_probe_r;
  logic signed [19:0] sph_pos [MaxSpheres][3];
  logic [15:0] sph_rad [MaxSpheres];
  int chain_next [MaxSpheres];
  int head_tab [CellSlots];
  int n_spheres;
  logic [31:0] hits;
  logic [31:0] trials;

  in_item_t items_to_send[$];
  out_item_t due_results[$];
  int errors = 0;
  int accepted = 0;

  // generator-side bookkeeping
  logic signed [19:0] load_spots[$][3];
  int loads_since_clear = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint eff_cells(logic [4:0] c);
    if (c == 0) return 1;
    if (c > MaxCellsAxis) return MaxCellsAxis;
    return c;
  endfunction

  function automatic longint eff_box(logic [19:0] b);
    return (b == 0) ? 1 : b;
  endfunction

  function automatic longint cell_of(longint pos, longint bx, longint nc);
    longint p;
    longint q;
    p = pos + bx / 2;
    if (p < 0) return 0;
    q = (p * nc) / bx;
    return (q >= nc) ? nc - 1 : q;
  endfunction

  function automatic longint unsigned sqr(longint d);
    longint unsigned m;
    m = (d < 0) ? -d : d;
    return m * m;
  endfunction

  function automatic void clear_all();
    for (int i = 0; i < CellSlots; i++) head_tab[i] = MaxSpheres;
    n_spheres = 0;
    hits = 0;
    trials = 0;
  endfunction

  function automatic bit probe_overlaps(longint p [3]);
    longint nc [3];
    longint bx [3];
    longint c [3];
    longint j [3];
    longint s [3];
    longint k;
    longint unsigned d2;
    longint unsigned rs;
    int n;
    int steps;
    for (int a = 0; a < 3; a++) begin
      nc[a] = eff_cells(m_cells[a]);
      bx[a] = eff_box(m_box[a]);
      c[a] = cell_of(p[a], bx[a], nc[a]);
    end
    for (int dz = -1; dz <= 1; dz++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++) begin
          j[0] = c[0] + dx;
          j[1] = c[1] + dy;
          j[2] = c[2] + dz;
          for (int a = 0; a < 3; a++) begin
            s[a] = 0;
            if (j[a] < 0) begin
              s[a] = -bx[a];
              j[a] = nc[a] - 1;
            end else if (j[a] >= nc[a]) begin
              s[a] = bx[a];
              j[a] = 0;
            end
          end
          n = head_tab[(j[2] * nc[1] + j[1]) * nc[0] + j[0]];
          steps = 0;
          while (n < n_spheres && n < MaxSpheres && steps < MaxSpheres) begin
            d2 = 0;
            for (int a = 0; a < 3; a++) begin
              k = sph_pos[n][a];
              d2 += sqr(k + s[a] - p[a]);
            end
            rs = longint'(m_probe_r) + longint'(sph_rad[n]);
            if (4 * d2 < rs * rs) return 1;
            n = chain_next[n];
            steps++;
          end
        end
    return 0;
  endfunction

  function automatic void predict(in_item_t it);
    out_item_t r;
    longint p [3];
    longint nc [3];
    longint slot;
    r = '0;
    p[0] = it.pos_x;
    p[1] = it.pos_y;
    p[2] = it.pos_z;
    case (it.op)
      OP_CLEAR: clear_all();
      OP_LOAD: begin
        if (n_spheres >= MaxSpheres) begin
          r.status = 1'b1;
        end else begin
          for (int a = 0; a < 3; a++) nc[a] = eff_cells(m_cells[a]);
          slot = (cell_of(p[2], eff_box(m_box[2]), nc[2]) * nc[1]
                 + cell_of(p[1], eff_box(m_box[1]), nc[1])) * nc[0]
                 + cell_of(p[0], eff_box(m_box[0]), nc[0]);
          sph_pos[n_spheres][0] = it.pos_x;
          sph_pos[n_spheres][1] = it.pos_y;
          sph_pos[n_spheres][2] = it.pos_z;
          sph_rad[n_spheres] = it.sphere_radius;
          chain_next[n_spheres] = head_tab[slot];
          head_tab[slot] = n_spheres;
          n_spheres++;
        end
      end
      OP_PROBE: begin
        if (probe_overlaps(p)) begin
          r.overlap = 1'b1;
          if (hits != 32'hFFFF_FFFF) hits++;
        end
        if (trials != 32'hFFFF_FFFF) trials++;
      end
      default: ;
    endcase
    r.hit_total = hits;
    r.trial_total = trials;
    due_results.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_index)
        REG_CELLS_X: m_cells[0] <= cfg_data[4:0];
        REG_CELLS_Y: m_cells[1] <= cfg_data[4:0];
        REG_CELLS_Z: m_cells[2] <= cfg_data[4:0];
        REG_BOX_X:   m_box[0] <= cfg_data;
        REG_BOX_Y:   m_box[1] <= cfg_data;
        REG_BOX_Z:   m_box[2] <= cfg_data;
        REG_PROBE_R: m_probe_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // driver: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict(in_data);
        accepted++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 0;
      end else if (items_to_send.size() > 0) begin
        in_data <= items_to_send.pop_front();
        in_valid <= 1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 300);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall pattern with one long hold-off
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (!hold_done && accepted >= 300) begin
        hold_done = 1;
        hold_left = 3000;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1;
      end else begin
        case (stall_mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        e = due_results.pop_front();
        if (out_data.overlap !== e.overlap)
          report_mismatch("overlap", out_data.overlap, e.overlap);
        if (out_data.status !== e.status)
          report_mismatch("status", out_data.status, e.status);
        if (out_data.hit_total !== e.hit_total)
          report_mismatch("hit_total", out_data.hit_total, e.hit_total);
        if (out_data.trial_total !== e.trial_total)
          report_mismatch("trial_total", out_data.trial_total, e.trial_total);
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [19:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_geometry(int cx, int cy, int cz, int bx, int by, int bz, int pr);
    cfg_write(REG_CELLS_X, 20'(cx));
    cfg_write(REG_CELLS_Y, 20'(cy));
    cfg_write(REG_CELLS_Z, 20'(cz));
    cfg_write(REG_BOX_X, 20'(bx));
    cfg_write(REG_BOX_Y, 20'(by));
    cfg_write(REG_BOX_Z, 20'(bz));
    cfg_write(REG_PROBE_R, 20'(pr));
  endtask

  task automatic wait_idle();
    while (items_to_send.size() > 0 || in_valid || due_results.size() > 0 || in_stall)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic void push(logic [1:0] op, int x, int y, int z, int rad);
    in_item_t it;
    it.op = op;
    it.pos_x = 20'(x);
    it.pos_y = 20'(y);
    it.pos_z = 20'(z);
    it.sphere_radius = 16'(rad);
    items_to_send.push_back(it);
    if (op == OP_CLEAR) begin
      loads_since_clear = 0;
      load_spots.delete();
    end else if (op == OP_LOAD) begin
      loads_since_clear++;
      load_spots.push_back('{20'(x), 20'(y), 20'(z)});
    end
  endfunction

  function automatic int pos_in(int bx);
    if (bx <= 1) return 0;
    if ($urandom_range(0, 9) == 0) return int'($signed(20'($urandom)));
    return int'($urandom_range(0, bx - 1)) - bx / 2;
  endfunction

  function automatic int near(int v, int spread);
    int r;
    r = v + int'($urandom_range(0, 2 * spread)) - spread;
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return r;
  endfunction

  function automatic void random_items(int count, int cap, int bx, int by, int bz, int spread);
    int k;
    int sel;
    int rad;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      rad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2 * spread);
      if (sel < 2 || loads_since_clear >= cap) begin
        push(OP_CLEAR, pos_in(bx), pos_in(by), pos_in(bz), $urandom_range(0, 65535));
      end else if (sel < 4) begin
        push(2'd3, pos_in(bx), pos_in(by), pos_in(bz), $urandom_range(0, 65535));
      end else if (sel < 50) begin
        push(OP_LOAD, pos_in(bx), pos_in(by), pos_in(bz), rad);
      end else if (load_spots.size() > 0 && sel < 80) begin
        k = $urandom_range(0, load_spots.size() - 1);
        push(OP_PROBE, near(load_spots[k][0], spread), near(load_spots[k][1], spread),
             near(load_spots[k][2], spread), $urandom_range(0, 65535));
      end else begin
        push(OP_PROBE, pos_in(bx), pos_in(by), pos_in(bz), $urandom_range(0, 65535));
      end
    end
  endfunction

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = REG_CELLS_X;
    cfg_data = '0;
    m_cells = '{5'd16, 5'd16, 5'd16};
    m_box = '{20'd65536, 20'd65536, 20'd65536};
    m_probe_r = 16'd384;
    for (int i = 0; i < MaxSpheres; i++) chain_next[i] = 0;
    clear_all();
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed, reset geometry
    push(2'd3, 1, 2, 3, 4);
    push(OP_PROBE, 0, 0, 0, 0);
    push(OP_LOAD, -524288, -524288, -524288, 0);
    push(OP_LOAD, 524287, 524287, 524287, 65535);
    push(OP_PROBE, 524287, 524287, 524287, 0);
    push(OP_PROBE, -524288, -524288, -524288, 65535);
    push(OP_LOAD, -32768 + 10, 0, 0, 384);
    push(OP_PROBE, 32767 - 10, 0, 0, 0);
    push(OP_LOAD, 1000, 1000, 1000, 384);
    push(OP_PROBE, 1384, 1000, 1000, 0);
    push(OP_PROBE, 1383, 1000, 1000, 0);
    push(OP_PROBE, 1000, 1000, 1000 - 384, 0);
    push(OP_CLEAR, 0, 0, 0, 0);
    push(OP_PROBE, 1000, 1000, 1000, 0);
    push(2'd3, -1, -1, -1, 65535);
    wait_idle();

    // full table: loads dropped once it holds every sphere
    for (int i = 0; i < MaxSpheres + 2; i++)
      push(OP_LOAD, pos_in(65536), pos_in(65536), pos_in(65536), $urandom_range(0, 1024));
    push(OP_PROBE, 0, 0, 0, 0);
    push(OP_PROBE, pos_in(65536), pos_in(65536), pos_in(65536), 0);
    push(OP_CLEAR, 0, 0, 0, 0);
    wait_idle();

    random_items(15, 48, 65536, 65536, 65536, 600);
    wait_idle();

    set_geometry(1, 1, 1, 2048, 2048, 2048, 300);
    random_items(15, 16, 2048, 2048, 2048, 400);
    wait_idle();

    set_geometry(0, 31, 2, 0, 1, 4096, 0);
    random_items(12, 16, 1, 1, 4096, 300);
    wait_idle();

    set_geometry(16, 16, 16, 1048575, 1048575, 1048575, 65535);
    random_items(15, 48, 1048575, 1048575, 1048575, 20000);
    wait_idle();

    set_geometry(3, 2, 7, 9000, 5000, 30000, 800);
    random_items(15, 32, 9000, 5000, 30000, 900);
    wait_idle();

    // new geometry over lists built under the old one
    set_geometry(16, 5, 9, 100000, 70000, 65536, 2000);
    random_items(12, 40, 100000, 70000, 65536, 2500);
    wait_idle();
    set_geometry(2, 16, 16, 60000, 65536, 65536, 0);
    random_items(12, 32, 60000, 65536, 65536, 1500);
    wait_idle();

    set_geometry(31, 0, 16, 65536, 0, 1048575, 1);
    random_items(12, 16, 65536, 1, 1048575, 1000);
    wait_idle();

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[files.f]
design/clsop_pkg.sv
design/clsop_cell_div.sv
design/cell_list_sphere_overlap_probe.sv
sim/tb_top.sv
